/* hw/rtl/dbht_pkg.sv */
package dbht_pkg;

    // Fixed field widths of the configuration registers and counters
    localparam int DIM_W      = 11;
    localparam int HLEN_W     = 5;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_ADDR_W = 2;
    localparam int CNT_W      = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Register values after reset
    localparam logic [HLEN_W-1:0] HLEN_RESET  = 5'd4;
    localparam logic [DIM_W-1:0]  IMG_W_RESET = 11'd640;
    localparam logic [DIM_W-1:0]  IMG_H_RESET = 11'd480;

    // Box lanes: one per coordinate, x in the lowest bits of a packed box
    localparam int LANES  = 4;
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_W = 2;
    localparam int LANE_H = 3;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_HISTORY_LENGTH = 2'd0,
        REG_IMAGE_WIDTH    = 2'd1,
        REG_IMAGE_HEIGHT   = 2'd2
    } dbht_reg_t;

    // Status of the averaging divider
    typedef struct packed {
        logic busy;
        logic done;
    } dbht_div_stat_t;

endpackage

/* hw/rtl/dbht_hist_mem.sv */
module dbht_hist_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 44
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          clr,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [DW-1:0]    rd_data_reg;

    // Mark written entries; drop all of them on a clear
    always_comb begin
        valid_next = valid_reg;
        if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
        if (clr) begin
            valid_next = '0;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Storage and registered read; an entry not yet written reads as zero
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/dbht_avg_div.sv */
module dbht_avg_div import dbht_pkg::*; #(
    parameter int SUMW = 16,
    parameter int NW   = 5,
    parameter int QW   = 11
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [NW-1:0]              divisor,
    input  logic [LANES-1:0][SUMW-1:0] dividend,
    output logic [LANES-1:0][QW-1:0]   quotient,
    output dbht_div_stat_t             stat
);

    localparam int STEPW = $clog2(SUMW + 1);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [STEPW-1:0]           step_reg, step_next;
    logic [LANES-1:0][SUMW-1:0] q_reg, q_next;
    logic [LANES-1:0][NW-1:0]   rem_reg, rem_next;
    logic [NW-1:0]              div_reg, div_next;

    logic [LANES-1:0][NW:0]     shifted;
    logic [LANES-1:0][NW:0]     diff;
    logic [LANES-1:0]           ge;

    // One restoring step per cycle in every lane, all lanes share the divisor
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        for (int l = 0; l < LANES; l++) begin
            shifted[l] = {rem_reg[l], q_reg[l][SUMW-1]};
            diff[l]    = shifted[l] - {1'b0, div_reg};
            ge[l]      = shifted[l] >= {1'b0, div_reg};
        end
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            q_next    = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            for (int l = 0; l < LANES; l++) begin
                q_next[l]   = {q_reg[l][SUMW-2:0], ge[l]};
                rem_next[l] = ge[l] ? diff[l][NW-1:0] : shifted[l][NW-1:0];
            end
            if (step_reg == STEPW'(SUMW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    // The average never exceeds one coordinate, so the low bits hold it
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            quotient[l] = q_reg[l][QW-1:0];
        end
    end

    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

/* hw/rtl/detection_box_history_tracker.sv */
// Channel  Direction  Transfer carries
// s_*      in         one frame: tdata = det_x, det_y, det_w, det_h; tuser = found
// m_*      out        one result: tdata = box, doubled center, frames_tracked; tuser = lost
// cfg_*    in         register write: index in cfg_addr, value in cfg_wr_data
//
// One averaging pass reads N history entries one per cycle from the memory port and
// then runs the 4-lane bit-serial divider over SUMW = COORD_BITS + clog2(MAX_HISTORY+1)
// dividend bits. A tested detection takes a pass, the overlap math and, unless the track
// is cleared or lost, a second pass; a first detection first fills all N entries.
// Reset is synchronous; history entries clear at once through per-entry valid bits.
// A new frame is taken only in the idle state; a result waiting on m_tready stalls
// only the delivery of the next result, not its computation.
module detection_box_history_tracker import dbht_pkg::*; #(
    parameter int MAX_HISTORY = 16,
    parameter int COORD_BITS  = 11,
    localparam int CW         = COORD_BITS + 1,
    localparam int BOX_W      = LANES * COORD_BITS,
    localparam int S_TDATA_W  = ((BOX_W + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((BOX_W + 2 * CW + CNT_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: det_x, det_y, det_w, det_h (lowest bit up)
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: found
    input  logic [0:0]            s_tuser,
    // m_tdata: box_x, box_y, box_w, box_h, center_x2, center_y2, frames_tracked
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    // m_tuser: lost
    output logic [0:0]            m_tuser,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int NW      = $clog2(MAX_HISTORY + 1);
    localparam int AW      = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
    localparam int SUMW    = COORD_BITS + NW;
    localparam int EW      = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 2;
    localparam int AREA_W  = 2 * COORD_BITS;
    localparam int SCALE_W = AREA_W + NW;

    typedef enum logic [15:0] {
        ST_IDLE    = 16'h0001,
        ST_SUM     = 16'h0002,
        ST_DIV_GO  = 16'h0004,
        ST_DIV     = 16'h0008,
        ST_OVL     = 16'h0010,
        ST_MUL_OV  = 16'h0020,
        ST_MUL_DET = 16'h0040,
        ST_MUL_SCL = 16'h0080,
        ST_DECIDE  = 16'h0100,
        ST_FILL    = 16'h0200,
        ST_WRITE   = 16'h0400,
        ST_ACCEPT  = 16'h0800,
        ST_MISS    = 16'h1000,
        ST_POST    = 16'h2000,
        ST_CLIP    = 16'h4000,
        ST_OUT     = 16'h8000
    } state_t;

    // Control state
    state_t              state_reg, state_next;
    logic [NW-1:0]       cnt_reg, cnt_next;
    logic                post_reg, post_next;
    logic                fresh_reg, fresh_next;
    logic [AW-1:0]       write_slot_reg, write_slot_next;
    logic [CNT_W-1:0]    miss_count_reg, miss_count_next;
    logic [CNT_W-1:0]    acc_count_reg, acc_count_next;
    logic [CW-1:0]       center_x_reg, center_x_next;
    logic [CW-1:0]       center_y_reg, center_y_next;
    logic [HLEN_W-1:0]   hist_len_reg, hist_len_next;
    logic [DIM_W-1:0]    img_w_reg, img_w_next;
    logic [DIM_W-1:0]    img_h_reg, img_h_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // Payload
    logic [BOX_W-1:0]            det_reg, det_next;
    logic [NW-1:0]               n_reg, n_next;
    logic [LANES-1:0][SUMW-1:0]  sum_reg, sum_next;
    logic [COORD_BITS-1:0]       ov_w_reg, ov_w_next;
    logic [COORD_BITS-1:0]       ov_h_reg, ov_h_next;
    logic [AREA_W-1:0]           area_ov_reg, area_ov_next;
    logic [AREA_W-1:0]           area_det_reg, area_det_next;
    logic [SCALE_W-1:0]          scaled_reg, scaled_next;
    logic [BOX_W-1:0]            res_box_reg, res_box_next;
    logic [CW-1:0]               res_cx_reg, res_cx_next;
    logic [CW-1:0]               res_cy_reg, res_cy_next;
    logic                        res_lost_reg, res_lost_next;
    logic [CNT_W-1:0]            res_frames_reg, res_frames_next;
    logic [M_TDATA_W-1:0]        m_data_reg, m_data_next;
    logic                        m_lost_reg, m_lost_next;

    // Memory and divider hookup
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic                        mem_clr;
    logic [AW-1:0]               mem_raddr;
    logic [BOX_W-1:0]            mem_rdata;
    logic                        div_start;
    logic [LANES-1:0][COORD_BITS-1:0] div_q;
    dbht_div_stat_t              div_stat;

    logic [NW-1:0]               n_eff;
    logic                        fresh_use;
    logic [NW-1:0]               slot_use;
    logic [NW-1:0]               slot_inc;

    // Overlap of detection and average, in coordinate width plus one
    logic [CW-1:0] ov_dx, ov_dy, ov_dw, ov_dh;
    logic [CW-1:0] ov_ax, ov_ay, ov_aw, ov_ah;
    logic [CW-1:0] ov_x1, ov_y1, ov_ex, ov_ey, ov_dex, ov_dey, ov_aex, ov_aey;
    logic [CW-1:0] ov_wd, ov_hd;
    logic          ov_hit;

    // Clip of the average against the image
    logic [EW-1:0] cl_ax, cl_ay, cl_end_x, cl_end_y, cl_lim_x, cl_lim_y;
    logic [EW-1:0] cl_x2, cl_y2, cl_w, cl_h, cl_cx, cl_cy;
    logic          cl_hit;

    dbht_hist_mem #(
        .DEPTH (MAX_HISTORY),
        .AW    (AW),
        .DW    (BOX_W)
    ) u_hist_mem (
        .clk     (aclk),
        .rst_n   (aresetn),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (det_reg),
        .clr     (mem_clr),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    dbht_avg_div #(
        .SUMW (SUMW),
        .NW   (NW),
        .QW   (COORD_BITS)
    ) u_avg_div (
        .clk      (aclk),
        .rst_n    (aresetn),
        .start    (div_start),
        .divisor  (n_reg),
        .dividend (sum_reg),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // Effective history length: zero acts as one, large values saturate
    always_comb begin
        if (hist_len_reg == '0) begin
            n_eff = NW'(1);
        end else if (int'(hist_len_reg) > MAX_HISTORY) begin
            n_eff = NW'(MAX_HISTORY);
        end else begin
            n_eff = NW'(hist_len_reg);
        end
    end

    assign fresh_use = fresh_reg || (n_eff == NW'(1));

    // Ring slot, wrapped to the current length before use
    assign slot_use = (NW'(write_slot_reg) >= n_reg) ? '0 : NW'(write_slot_reg);
    assign slot_inc = (slot_use + 1'b1 == n_reg) ? '0 : slot_use + 1'b1;

    // Overlap of the held detection with the current average
    assign ov_dx  = CW'(det_reg[LANE_X*COORD_BITS +: COORD_BITS]);
    assign ov_dy  = CW'(det_reg[LANE_Y*COORD_BITS +: COORD_BITS]);
    assign ov_dw  = CW'(det_reg[LANE_W*COORD_BITS +: COORD_BITS]);
    assign ov_dh  = CW'(det_reg[LANE_H*COORD_BITS +: COORD_BITS]);
    assign ov_ax  = CW'(div_q[LANE_X]);
    assign ov_ay  = CW'(div_q[LANE_Y]);
    assign ov_aw  = CW'(div_q[LANE_W]);
    assign ov_ah  = CW'(div_q[LANE_H]);
    assign ov_x1  = (ov_dx > ov_ax) ? ov_dx : ov_ax;
    assign ov_y1  = (ov_dy > ov_ay) ? ov_dy : ov_ay;
    assign ov_dex = ov_dx + ov_dw;
    assign ov_dey = ov_dy + ov_dh;
    assign ov_aex = ov_ax + ov_aw;
    assign ov_aey = ov_ay + ov_ah;
    assign ov_ex  = (ov_dex < ov_aex) ? ov_dex : ov_aex;
    assign ov_ey  = (ov_dey < ov_aey) ? ov_dey : ov_aey;
    assign ov_hit = (ov_ex > ov_x1) && (ov_ey > ov_y1);
    assign ov_wd  = ov_ex - ov_x1;
    assign ov_hd  = ov_ey - ov_y1;

    // Average clipped to the image rectangle
    assign cl_ax    = EW'(div_q[LANE_X]);
    assign cl_ay    = EW'(div_q[LANE_Y]);
    assign cl_end_x = cl_ax + EW'(div_q[LANE_W]);
    assign cl_end_y = cl_ay + EW'(div_q[LANE_H]);
    assign cl_lim_x = EW'(img_w_reg);
    assign cl_lim_y = EW'(img_h_reg);
    assign cl_x2    = (cl_end_x < cl_lim_x) ? cl_end_x : cl_lim_x;
    assign cl_y2    = (cl_end_y < cl_lim_y) ? cl_end_y : cl_lim_y;
    assign cl_hit   = (cl_x2 > cl_ax) && (cl_y2 > cl_ay);
    assign cl_w     = cl_x2 - cl_ax;
    assign cl_h     = cl_y2 - cl_ay;
    assign cl_cx    = cl_ax + cl_x2;
    assign cl_cy    = cl_ay + cl_y2;

    // Frame sequencer
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        post_next       = post_reg;
        fresh_next      = fresh_reg;
        write_slot_next = write_slot_reg;
        miss_count_next = miss_count_reg;
        acc_count_next  = acc_count_reg;
        center_x_next   = center_x_reg;
        center_y_next   = center_y_reg;
        hist_len_next   = hist_len_reg;
        img_w_next      = img_w_reg;
        img_h_next      = img_h_reg;
        m_tvalid_next   = m_tvalid_reg;
        det_next        = det_reg;
        n_next          = n_reg;
        sum_next        = sum_reg;
        ov_w_next       = ov_w_reg;
        ov_h_next       = ov_h_reg;
        area_ov_next    = area_ov_reg;
        area_det_next   = area_det_reg;
        scaled_next     = scaled_reg;
        res_box_next    = res_box_reg;
        res_cx_next     = res_cx_reg;
        res_cy_next     = res_cy_reg;
        res_lost_next   = res_lost_reg;
        res_frames_next = res_frames_reg;
        m_data_next     = m_data_reg;
        m_lost_next     = m_lost_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_clr         = 1'b0;
        mem_raddr       = '0;
        div_start       = 1'b0;

        // Register writes
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_HISTORY_LENGTH: hist_len_next = cfg_wr_data[HLEN_W-1:0];
                REG_IMAGE_WIDTH:    img_w_next    = cfg_wr_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:   img_h_next    = cfg_wr_data[DIM_W-1:0];
                default: ;
            endcase
        end

        // Drop the output once its transfer completes
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    det_next = s_tdata[BOX_W-1:0];
                    n_next   = n_eff;
                    cnt_next = '0;
                    if (n_eff == NW'(1)) begin
                        fresh_next = 1'b1;
                    end
                    if (s_tuser[0] && !fresh_use) begin
                        post_next  = 1'b0;
                        sum_next   = '0;
                        state_next = ST_SUM;
                    end else if (s_tuser[0]) begin
                        state_next = ST_FILL;
                    end else begin
                        state_next = ST_MISS;
                    end
                end
            end
            ST_SUM: begin
                // Issue one read per cycle; add the entry from the previous read, whose data is registered
                mem_raddr = (cnt_reg < n_reg) ? cnt_reg[AW-1:0] : '0;
                if (cnt_reg != '0) begin
                    for (int l = 0; l < LANES; l++) begin
                        sum_next[l] = sum_reg[l]
                                    + SUMW'(mem_rdata[l*COORD_BITS +: COORD_BITS]);
                    end
                end
                if (cnt_reg == n_reg) begin
                    state_next = ST_DIV_GO;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIV_GO: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = post_reg ? ST_CLIP : ST_OVL;
                end
            end
            ST_OVL: begin
                ov_w_next  = ov_hit ? ov_wd[COORD_BITS-1:0] : '0;
                ov_h_next  = ov_hit ? ov_hd[COORD_BITS-1:0] : '0;
                state_next = ST_MUL_OV;
            end
            ST_MUL_OV: begin
                area_ov_next = AREA_W'(ov_w_reg * ov_h_reg);
                state_next   = ST_MUL_DET;
            end
            ST_MUL_DET: begin
                area_det_next = AREA_W'(det_reg[LANE_W*COORD_BITS +: COORD_BITS]
                                      * det_reg[LANE_H*COORD_BITS +: COORD_BITS]);
                state_next    = ST_MUL_SCL;
            end
            ST_MUL_SCL: begin
                scaled_next = SCALE_W'(area_ov_reg * n_reg);
                state_next  = ST_DECIDE;
            end
            ST_DECIDE: begin
                // overlap > floor(area / N) exactly when overlap * N > area
                state_next = (scaled_reg > SCALE_W'(area_det_reg)) ? ST_WRITE : ST_MISS;
            end
            ST_FILL: begin
                // First detection fills every active entry
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[AW-1:0];
                if (cnt_reg + 1'b1 == n_reg) begin
                    fresh_next = 1'b0;
                    state_next = ST_ACCEPT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_WRITE: begin
                mem_we          = 1'b1;
                mem_waddr       = slot_use[AW-1:0];
                write_slot_next = slot_inc[AW-1:0];
                state_next      = ST_ACCEPT;
            end
            ST_ACCEPT: begin
                if (acc_count_reg != CNT_MAX) begin
                    acc_count_next = acc_count_reg + 1'b1;
                end
                miss_count_next = '0;
                state_next      = ST_POST;
            end
            ST_MISS: begin
                if (miss_count_reg != CNT_MAX) begin
                    miss_count_next = miss_count_reg + 1'b1;
                end
                state_next = ST_POST;
            end
            ST_POST: begin
                if (miss_count_reg == CNT_W'(n_reg)) begin
                    // Clear the track and recenter on the image
                    mem_clr         = 1'b1;
                    fresh_next      = 1'b1;
                    acc_count_next  = '0;
                    center_x_next   = cl_lim_x[CW-1:0];
                    center_y_next   = cl_lim_y[CW-1:0];
                    res_box_next    = '0;
                    res_cx_next     = cl_lim_x[CW-1:0];
                    res_cy_next     = cl_lim_y[CW-1:0];
                    res_lost_next   = 1'b0;
                    res_frames_next = '0;
                    state_next      = ST_OUT;
                end else if (miss_count_reg > CNT_W'(n_reg)) begin
                    res_box_next    = '0;
                    res_cx_next     = center_x_reg;
                    res_cy_next     = center_y_reg;
                    res_lost_next   = 1'b1;
                    res_frames_next = acc_count_reg;
                    state_next      = ST_OUT;
                end else begin
                    cnt_next   = '0;
                    sum_next   = '0;
                    post_next  = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_CLIP: begin
                if (cl_hit) begin
                    res_box_next  = {cl_h[COORD_BITS-1:0], cl_w[COORD_BITS-1:0],
                                     div_q[LANE_Y], div_q[LANE_X]};
                    center_x_next = cl_cx[CW-1:0];
                    center_y_next = cl_cy[CW-1:0];
                    res_cx_next   = cl_cx[CW-1:0];
                    res_cy_next   = cl_cy[CW-1:0];
                end else begin
                    res_box_next  = '0;
                    res_cx_next   = center_x_reg;
                    res_cy_next   = center_y_reg;
                end
                res_lost_next   = 1'b0;
                res_frames_next = acc_count_reg;
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                // Hold the result until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_data_next   = M_TDATA_W'({res_frames_reg, res_cy_reg, res_cx_reg,
                                                res_box_reg});
                    m_lost_next   = res_lost_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            post_reg       <= 1'b0;
            fresh_reg      <= 1'b1;
            write_slot_reg <= '0;
            miss_count_reg <= '0;
            acc_count_reg  <= '0;
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            hist_len_reg   <= HLEN_RESET;
            img_w_reg      <= IMG_W_RESET;
            img_h_reg      <= IMG_H_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            post_reg       <= post_next;
            fresh_reg      <= fresh_next;
            write_slot_reg <= write_slot_next;
            miss_count_reg <= miss_count_next;
            acc_count_reg  <= acc_count_next;
            center_x_reg   <= center_x_next;
            center_y_reg   <= center_y_next;
            hist_len_reg   <= hist_len_next;
            img_w_reg      <= img_w_next;
            img_h_reg      <= img_h_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        det_reg        <= det_next;
        n_reg          <= n_next;
        sum_reg        <= sum_next;
        ov_w_reg       <= ov_w_next;
        ov_h_reg       <= ov_h_next;
        area_ov_reg    <= area_ov_next;
        area_det_reg   <= area_det_next;
        scaled_reg     <= scaled_next;
        res_box_reg    <= res_box_next;
        res_cx_reg     <= res_cx_next;
        res_cy_reg     <= res_cy_next;
        res_lost_reg   <= res_lost_next;
        res_frames_reg <= res_frames_next;
        m_data_reg     <= m_data_next;
        m_lost_reg     <= m_lost_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_lost_reg;

`ifndef NO_ASSERTIONS
    a_no_write_during_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM) |-> !mem_we)
        else $error("history written during an averaging pass");

    a_accept_clears_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACCEPT) |=> (miss_count_reg == '0))
        else $error("miss count not cleared by an accepted detection");

    a_lost_empty_box: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_lost_reg) |-> (m_data_reg[BOX_W-1:0] == '0))
        else $error("lost result carries a box");

    a_center_matches_box: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_lost_reg && (m_data_reg[LANE_W*COORD_BITS +: COORD_BITS] != '0))
        |-> (m_data_reg[BOX_W +: CW] == ({m_data_reg[LANE_X*COORD_BITS +: COORD_BITS], 1'b0}
             + CW'(m_data_reg[LANE_W*COORD_BITS +: COORD_BITS]))))
        else $error("doubled center does not match the reported box");

    a_divider_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_GO) |=> (div_stat.busy && !div_stat.done))
        else $error("divider did not start");
`endif

endmodule

/* bench/tb.sv */
module tb import dbht_pkg::*; ();

    localparam int HIST_DEPTH = 16;
    localparam int S_BITS     = ((LANES * DIM_W + 7) / 8) * 8;
    localparam int M_BITS     = ((LANES * DIM_W + 2 * (DIM_W + 1) + CNT_W + 7) / 8) * 8;
    localparam int PHASES     = 12;
    localparam int PHASE_LEN  = 158;
    localparam int MAX_PRINTS = 100;

    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } rect_t;

    typedef struct packed {
        logic [DIM_W-1:0] box_x;
        logic [DIM_W-1:0] box_y;
        logic [DIM_W-1:0] box_w;
        logic [DIM_W-1:0] box_h;
        logic [DIM_W:0]   center_x2;
        logic [DIM_W:0]   center_y2;
        logic             lost;
        logic [CNT_W-1:0] frames;
    } track_t;

    typedef struct packed {
        logic   found;
        rect_t  det;
        logic   typed;
        track_t want;
    } frame_row_t;

    localparam track_t NO_RESULT = '0;

    // Opening frames at the reset settings (N = 4, 640 x 480)
    frame_row_t opening_frames [20] = '{
        // miss on an empty history
        '{1'b0, '{'0, '0, '0, '0}, 1'b1, '{'0, '0, '0, '0, '0, '0, 1'b0, '0}},
        // first detection fills the history
        '{1'b1, '{11'd100, 11'd100, 11'd200, 11'd100}, 1'b1,
          '{11'd100, 11'd100, 11'd200, 11'd100, 12'd400, 12'd300, 1'b0, 16'd1}},
        '{1'b1, '{11'd100, 11'd100, 11'd200, 11'd100}, 1'b1,
          '{11'd100, 11'd100, 11'd200, 11'd100, 12'd400, 12'd300, 1'b0, 16'd2}},
        '{1'b1, '{11'd110, 11'd100, 11'd200, 11'd100}, 1'b0, NO_RESULT},
        // disjoint detection is rejected
        '{1'b1, '{11'd1000, 11'd1000, 11'd50, 11'd50}, 1'b0, NO_RESULT},
        '{1'b0, '{'0, '0, '0, '0}, 1'b0, NO_RESULT},
        '{1'b0, '{'0, '0, '0, '0}, 1'b0, NO_RESULT},
        // N misses clear the history and move to the image center
        '{1'b0, '{'0, '0, '0, '0}, 1'b1, '{'0, '0, '0, '0, 12'd640, 12'd480, 1'b0, '0}},
        // lost: only the center is valid
        '{1'b0, '{'0, '0, '0, '0}, 1'b1, '{'0, '0, '0, '0, 12'd640, 12'd480, 1'b1, '0}},
        // largest box lies outside the image: empty clip keeps the center
        '{1'b1, '{'1, '1, '1, '1}, 1'b1, '{'0, '0, '0, '0, 12'd640, 12'd480, 1'b0, 16'd1}},
        '{1'b1, '{'0, '0, '0, '0}, 1'b1, '{'0, '0, '0, '0, 12'd640, 12'd480, 1'b0, 16'd1}},
        '{1'b1, '{'1, '1, '1, '1}, 1'b1, '{'0, '0, '0, '0, 12'd640, 12'd480, 1'b0, 16'd2}},
        '{1'b1, '{'0, '0, '1, '1}, 1'b1, '{'0, '0, '0, '0, 12'd640, 12'd480, 1'b0, 16'd2}},
        '{1'b0, '{'0, '0, '0, '0}, 1'b1, '{'0, '0, '0, '0, 12'd640, 12'd480, 1'b0, 16'd2}},
        '{1'b0, '{'0, '0, '0, '0}, 1'b1, '{'0, '0, '0, '0, 12'd640, 12'd480, 1'b0, 16'd2}},
        '{1'b0, '{'0, '0, '0, '0}, 1'b1, '{'0, '0, '0, '0, 12'd640, 12'd480, 1'b0, '0}},
        // full-image box
        '{1'b1, '{'0, '0, 11'd640, 11'd480}, 1'b1,
          '{'0, '0, 11'd640, 11'd480, 12'd640, 12'd480, 1'b0, 16'd1}},
        '{1'b1, '{11'd639, 11'd479, 11'd1, 11'd1}, 1'b0, NO_RESULT},
        '{1'b1, '{11'd1024, 11'd1024, 11'd1023, 11'd1023}, 1'b0, NO_RESULT},
        '{1'b0, '{'1, '1, '1, '1}, 1'b0, NO_RESULT}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_BITS-1:0]     s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_BITS-1:0]     m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    // Register shadow and tracker state of the predictor
    logic [HLEN_W-1:0] cfg_hlen  = HLEN_RESET;
    logic [DIM_W-1:0]  cfg_img_w = IMG_W_RESET;
    logic [DIM_W-1:0]  cfg_img_h = IMG_H_RESET;
    rect_t             hist [HIST_DEPTH] = '{default: '0};
    int                slot     = 0;
    bit                fresh    = 1'b1;
    int                misses   = 0;
    int                accepted = 0;
    logic [DIM_W:0]    ctr_x2   = '0;
    logic [DIM_W:0]    ctr_y2   = '0;

    track_t pending_tracks [$];
    int     mismatches   = 0;
    int     results_seen = 0;
    bit     steady       = 1'b0;
    rect_t  aim          = '{11'd100, 11'd100, 11'd200, 11'd100};
    int     miss_left    = 0;

    detection_box_history_tracker #(
        .MAX_HISTORY (HIST_DEPTH),
        .COORD_BITS  (DIM_W)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #10000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int hist_len();
        int n;
        n = cfg_hlen;
        if (n == 0) n = 1;
        if (n > HIST_DEPTH) n = HIST_DEPTH;
        return n;
    endfunction

    function automatic rect_t overlap(rect_t a, rect_t b);
        int x1, y1, x2, y2;
        rect_t r;
        r  = '0;
        x1 = (a.x > b.x) ? a.x : b.x;
        y1 = (a.y > b.y) ? a.y : b.y;
        x2 = int'(a.x) + int'(a.w);
        y2 = int'(a.y) + int'(a.h);
        if (int'(b.x) + int'(b.w) < x2) x2 = int'(b.x) + int'(b.w);
        if (int'(b.y) + int'(b.h) < y2) y2 = int'(b.y) + int'(b.h);
        if (x2 > x1 && y2 > y1) begin
            r.x = DIM_W'(x1);
            r.y = DIM_W'(y1);
            r.w = DIM_W'(x2 - x1);
            r.h = DIM_W'(y2 - y1);
        end
        return r;
    endfunction

    // Truncated mean of the first n history entries
    function automatic rect_t history_mean(int n);
        int sx, sy, sw, sh;
        rect_t a;
        sx = 0; sy = 0; sw = 0; sh = 0;
        for (int i = 0; i < n; i++) begin
            sx += hist[i].x;
            sy += hist[i].y;
            sw += hist[i].w;
            sh += hist[i].h;
        end
        a.x = DIM_W'(sx / n);
        a.y = DIM_W'(sy / n);
        a.w = DIM_W'(sw / n);
        a.h = DIM_W'(sh / n);
        return a;
    endfunction

    // Fill the first n entries on a fresh start, else write the ring slot
    function automatic void store_box(rect_t d, int n);
        if (fresh) begin
            for (int i = 0; i < n; i++) hist[i] = d;
            fresh = 1'b0;
        end else begin
            if (slot >= n) slot = 0;
            hist[slot] = d;
            slot = (slot + 1) % n;
        end
        if (accepted < 65535) accepted++;
        misses = 0;
    endfunction

    // Advance the tracker by one frame and return its result
    function automatic track_t next_track_result(logic found, rect_t d);
        int n;
        rect_t ov, clip, img;
        track_t r;
        n = hist_len();
        r = '0;
        if (n == 1) fresh = 1'b1;
        if (found) begin
            if (fresh) begin
                store_box(d, n);
            end else begin
                ov = overlap(d, history_mean(n));
                if (int'(ov.w) * int'(ov.h) > (int'(d.w) * int'(d.h)) / n)
                    store_box(d, n);
                else if (misses < 65535)
                    misses++;
            end
        end else if (misses < 65535) begin
            misses++;
        end

        if (misses == n) begin
            foreach (hist[i]) hist[i] = '0;
            fresh    = 1'b1;
            accepted = 0;
            ctr_x2   = {1'b0, cfg_img_w};
            ctr_y2   = {1'b0, cfg_img_h};
        end else if (misses > n) begin
            r.center_x2 = ctr_x2;
            r.center_y2 = ctr_y2;
            r.lost      = 1'b1;
            r.frames    = CNT_W'(accepted);
            return r;
        end

        img.x = '0;
        img.y = '0;
        img.w = cfg_img_w;
        img.h = cfg_img_h;
        clip  = overlap(history_mean(n), img);
        if (clip.w > 0 && clip.h > 0) begin
            ctr_x2 = (DIM_W + 1)'(2 * int'(clip.x) + int'(clip.w));
            ctr_y2 = (DIM_W + 1)'(2 * int'(clip.y) + int'(clip.h));
        end
        r.box_x     = clip.x;
        r.box_y     = clip.y;
        r.box_w     = clip.w;
        r.box_h     = clip.h;
        r.center_x2 = ctr_x2;
        r.center_y2 = ctr_y2;
        r.frames    = CNT_W'(accepted);
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] jiggle(logic [DIM_W-1:0] v);
        int t;
        t = int'(v) + $urandom_range(0, 6) - 3;
        if (t < 0) t = 0;
        if (t > 2047) t = 2047;
        return DIM_W'(t);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch on result %0d: %s got %0d want %0d",
                     results_seen, what, got, want);
    endtask

    // Hold the frame until transfer, then queue what it should produce
    task automatic send_frame(logic found, rect_t d, logic typed, track_t want);
        int gap;
        track_t pred;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= found;
        s_tdata  <= {{(S_BITS - LANES * DIM_W){1'b0}}, d.h, d.w, d.y, d.x};
        do @(posedge aclk); while (!s_tready);
        pred = next_track_result(found, d);
        pending_tracks.push_back(typed ? want : pred);
    endtask

    // Stop sending until every queued result has been taken
    task automatic drain_tracks();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_tracks.size() != 0);
    endtask

    task automatic write_reg(dbht_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        case (idx)
            REG_HISTORY_LENGTH: cfg_hlen  = val[HLEN_W-1:0];
            REG_IMAGE_WIDTH:    cfg_img_w = val[DIM_W-1:0];
            REG_IMAGE_HEIGHT:   cfg_img_h = val[DIM_W-1:0];
            default: ;
        endcase
    endtask

    // Result side: random stalls, compare each transfer with the oldest expectation
    initial begin
        track_t got, want;
        int stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.box_x     = m_tdata[10:0];
            got.box_y     = m_tdata[21:11];
            got.box_w     = m_tdata[32:22];
            got.box_h     = m_tdata[43:33];
            got.center_x2 = m_tdata[55:44];
            got.center_y2 = m_tdata[67:56];
            got.frames    = m_tdata[83:68];
            got.lost      = m_tuser[0];
            results_seen++;
            if (pending_tracks.size() == 0) begin
                report_mismatch("unexpected result, box_x", got.box_x, 0);
            end else begin
                want = pending_tracks.pop_front();
                if (got.box_x !== want.box_x) report_mismatch("box_x", got.box_x, want.box_x);
                if (got.box_y !== want.box_y) report_mismatch("box_y", got.box_y, want.box_y);
                if (got.box_w !== want.box_w) report_mismatch("box_w", got.box_w, want.box_w);
                if (got.box_h !== want.box_h) report_mismatch("box_h", got.box_h, want.box_h);
                if (got.center_x2 !== want.center_x2)
                    report_mismatch("center_x2", got.center_x2, want.center_x2);
                if (got.center_y2 !== want.center_y2)
                    report_mismatch("center_y2", got.center_y2, want.center_y2);
                if (got.lost !== want.lost) report_mismatch("lost", got.lost, want.lost);
                if (got.frames !== want.frames)
                    report_mismatch("frames_tracked", got.frames, want.frames);
            end
        end
    end

    // Frame side: reset, opening frames, then randomized phases
    initial begin
        int r;
        int hl, iw, ih, span_w, span_h;
        logic found;
        rect_t d;

        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= REG_HISTORY_LENGTH;
        cfg_wr_data <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (opening_frames[i])
            send_frame(opening_frames[i].found, opening_frames[i].det,
                       opening_frames[i].typed, opening_frames[i].want);
        drain_tracks();

        for (int phase = 0; phase < PHASES; phase++) begin
            // Pick settings: extremes first, then random ones
            case (phase)
                0: begin hl = 1;  iw = 2047; ih = 2047; end
                1: begin hl = 16; iw = 2047; ih = 1;    end
                2: begin hl = 0;  iw = 1;    ih = 2047; end
                3: begin hl = 31; iw = 0;    ih = 480;  end
                4: begin hl = 2;  iw = 640;  ih = 0;    end
                default: begin
                    hl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(1, 16);
                    iw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
                                                     : $urandom_range(1, 2047);
                    ih = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
                                                     : $urandom_range(1, 2047);
                end
            endcase
            if (phase == 3)
                write_reg(REG_HISTORY_LENGTH, '1);
            else
                write_reg(REG_HISTORY_LENGTH, {6'($urandom), 5'(hl)});
            write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(iw));
            write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(ih));
            cfg_wr_en <= 1'b0;
            steady    = (phase % 4 == 3);
            miss_left = 0;

            for (int k = 0; k < PHASE_LEN; k++) begin
                r     = $urandom_range(0, 99);
                d.x   = DIM_W'($urandom);
                d.y   = DIM_W'($urandom);
                d.w   = DIM_W'($urandom);
                d.h   = DIM_W'($urandom);
                found = 1'b1;
                if (miss_left > 0) begin
                    miss_left--;
                    found = 1'b0;
                end else if (r < 6) begin
                    // start a run of misses, long enough at times to lose the track
                    miss_left = $urandom_range(0, hist_len() + 1);
                    found = 1'b0;
                end else if (r < 12) begin
                    // noise: leave the random box
                end else if (r == 12) begin
                    d = '1;
                end else begin
                    // follow a target inside the image, moving it now and then
                    if (r < 19) begin
                        span_w = (cfg_img_w == 0) ? 2047 : cfg_img_w;
                        span_h = (cfg_img_h == 0) ? 2047 : cfg_img_h;
                        aim.w  = DIM_W'($urandom_range(1, span_w));
                        aim.h  = DIM_W'($urandom_range(1, span_h));
                        aim.x  = DIM_W'($urandom_range(0, span_w - aim.w));
                        aim.y  = DIM_W'($urandom_range(0, span_h - aim.h));
                    end
                    d.x = jiggle(aim.x);
                    d.y = jiggle(aim.y);
                    d.w = (r == 13) ? '0 : jiggle(aim.w);
                    d.h = jiggle(aim.h);
                end
                send_frame(found, d, 1'b0, NO_RESULT);
                if ($urandom_range(0, 49) == 0) drain_tracks();
            end
            drain_tracks();
        end

        repeat (200) @(posedge aclk);
        if (mismatches == 0 && pending_tracks.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
